// ----- design/dcas_pkg.sv -----
package dcas_pkg;

	// DMA channel number this sequencer serves; EEPROM transfers exist only on channel 3
	localparam int unsigned CHANNEL        = 0;
	localparam int unsigned EEPROM_CHANNEL = 3;

	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned COUNT_W = 17;
	localparam int unsigned STEP_W  = 4;
	localparam int unsigned CFG_W   = 32;
	localparam int unsigned IDX_W   = 3;

	// cartridge EEPROM window is 0x0D000000 .. 0x0DFFFFFF: top byte 0x0D
	localparam logic [7:0] EEPROM_PAGE = 8'h0D;

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CTRL_INC        = 2'd0,
		CTRL_DEC        = 2'd1,
		CTRL_FIXED      = 2'd2,
		CTRL_INC_RELOAD = 2'd3
	} ctrl_t;

	typedef enum logic [1:0] {
		KIND_HALF      = 2'd0,
		KIND_WORD      = 2'd1,
		KIND_EEPROM_RD = 2'd2,
		KIND_EEPROM_WR = 2'd3
	} kind_t;

	typedef enum logic [IDX_W-1:0] {
		REG_SOURCE_BASE    = 3'd0,
		REG_DEST_BASE      = 3'd1,
		REG_WORD_MODE      = 3'd2,
		REG_SOURCE_CONTROL = 3'd3,
		REG_DEST_CONTROL   = 3'd4,
		REG_REPEAT_MODE    = 3'd5,
		REG_IRQ_ENABLE     = 3'd6,
		REG_UNIT_COUNT     = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  source_base;
		logic [ADDR_W-1:0]  dest_base;
		logic               word_mode;
		ctrl_t              source_control;
		ctrl_t              dest_control;
		logic               repeat_mode;
		logic               irq_enable;
		logic [COUNT_W-1:0] unit_count;
	} cfg_t;

	typedef struct packed {
		op_t  op;
		logic reload_request;
		logic eeprom_present;
	} item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] read_address;
		logic [ADDR_W-1:0] write_address;
		kind_t             access_kind;
		logic              last_unit;
		logic              enable_after;
		logic              irq_pulse;
	} result_t;

	// byte delta per unit, 4-bit two's complement
	function automatic logic [STEP_W-1:0] step_for(ctrl_t ctrl, logic word_mode);
		logic [STEP_W-1:0] size;
		size = word_mode ? 4'd4 : 4'd2;
		unique case (ctrl)
			CTRL_DEC:   step_for = 4'd0 - size;
			CTRL_FIXED: step_for = '0;
			default:    step_for = size;
		endcase
	endfunction

	function automatic logic [ADDR_W-1:0] widen(logic [STEP_W-1:0] s);
		widen = {{(ADDR_W-STEP_W){s[STEP_W-1]}}, s};
	endfunction

	function automatic logic in_eeprom(logic [ADDR_W-1:0] a);
		in_eeprom = (a[ADDR_W-1 -: 8] == EEPROM_PAGE);
	endfunction

	// clear bit 0 for halfwords, bits 1:0 for words
	function automatic logic [ADDR_W-1:0] align(logic [ADDR_W-1:0] a, logic word_mode);
		align = {a[ADDR_W-1:2], a[1] & ~word_mode, 1'b0};
	endfunction

endpackage

// ----- design/dma_channel_address_sequencer.sv -----
// DMA channel address sequencer.
// An accepted word waits in the input register; its decoded result is registered onto m_*.
// Throughput: one word per cycle unless stalled, set by the single address add per step.
// The input register stalls only on a step with a result, output full and not being drained.
// Reset (arst_n low, async): channel idle, count and addresses zero, unit_count = 1,
// other config zero, both pipeline registers empty.
module dma_channel_address_sequencer
	import dcas_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// configuration write port
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	// input stream
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [0] reload_request, [1] eeprom_present, [7:2] zero
	input  logic             s_tuser,   // [0] op (0 start, 1 step)
	// result stream
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [71:0]      m_tdata,   // [31:0] read_address, [63:32] write_address,
	                                    // [64] enable_after, [65] irq_pulse, [71:66] zero
	output logic [1:0]       m_tuser,   // [1:0] access_kind
	output logic             m_tlast    // last_unit
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    produce;
	logic    advance;
	result_t result;
	result_t result_s2;
	logic    valid_s2;

	dcas_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	// Stage 1 word moves on unless it has a result and the output slot is
	// occupied and not being drained this cycle.
	assign advance  = !valid_s1 || !produce || !valid_s2 || m_tready;
	assign s_tready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s_tvalid) begin
			item_s1.op             <= op_t'(s_tuser);
			item_s1.reload_request <= s_tdata[0];
			item_s1.eeprom_present <= s_tdata[1];
		end
	end

	// channel state and per-word decode
	dcas_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.item_valid(valid_s1),
		.item      (item_s1),
		.fire      (valid_s1 && advance),
		.produce   (produce),
		.result    (result)
	);

	// output register: holds one result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (valid_s1 && advance && produce) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance && produce) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'b0, result_s2.irq_pulse, result_s2.enable_after,
	                   result_s2.write_address, result_s2.read_address};
	assign m_tuser  = result_s2.access_kind;
	assign m_tlast  = result_s2.last_unit;

endmodule

// ----- design/dcas_cfg_regs.sv -----
module dcas_cfg_regs
	import dcas_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_base    <= '0;
			cfg_q.dest_base      <= '0;
			cfg_q.word_mode      <= 1'b0;
			cfg_q.source_control <= CTRL_INC;
			cfg_q.dest_control   <= CTRL_INC;
			cfg_q.repeat_mode    <= 1'b0;
			cfg_q.irq_enable     <= 1'b0;
			cfg_q.unit_count     <= COUNT_W'(1);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SOURCE_BASE:    cfg_q.source_base    <= cfg_data;
				REG_DEST_BASE:      cfg_q.dest_base      <= cfg_data;
				REG_WORD_MODE:      cfg_q.word_mode      <= cfg_data[0];
				REG_SOURCE_CONTROL: cfg_q.source_control <= ctrl_t'(cfg_data[1:0]);
				REG_DEST_CONTROL:   cfg_q.dest_control   <= ctrl_t'(cfg_data[1:0]);
				REG_REPEAT_MODE:    cfg_q.repeat_mode    <= cfg_data[0];
				REG_IRQ_ENABLE:     cfg_q.irq_enable     <= cfg_data[0];
				REG_UNIT_COUNT:     cfg_q.unit_count     <= cfg_data[COUNT_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/dcas_core.sv -----
module dcas_core
	import dcas_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    item_valid,
	input  item_t   item,
	input  logic    fire,
	output logic    produce,
	output result_t result
);

	logic               running_q;
	logic [COUNT_W-1:0] units_left_q;
	logic [ADDR_W-1:0]  src_addr_q;
	logic [ADDR_W-1:0]  dst_addr_q;
	logic [STEP_W-1:0]  src_step_q;
	logic [STEP_W-1:0]  dst_step_q;
	kind_t              kind_q;

	logic              is_start;
	logic              is_step;
	logic              zero_run;
	logic              last;
	logic [ADDR_W-1:0] src_start;
	logic [ADDR_W-1:0] dst_start;
	logic              ee_wr;
	logic              ee_rd;
	kind_t             kind_start;

	assign is_start = item_valid && (item.op == OP_START);
	assign is_step  = item_valid && (item.op == OP_STEP) && running_q;
	assign zero_run = is_step && (units_left_q == '0);
	assign produce  = is_step && (units_left_q != '0);
	assign last     = (units_left_q == COUNT_W'(1));

	// start: choose working addresses, then align to unit size
	always_comb begin
		logic [ADDR_W-1:0] s;
		logic [ADDR_W-1:0] d;
		s = src_addr_q;
		d = dst_addr_q;
		if (item.reload_request) begin
			s = cfg.source_base;
			d = cfg.dest_base;
		end else if (cfg.repeat_mode && cfg.dest_control == CTRL_INC_RELOAD) begin
			d = cfg.dest_base;
		end
		src_start = align(s, cfg.word_mode);
		dst_start = align(d, cfg.word_mode);
	end

	assign ee_wr = (CHANNEL == EEPROM_CHANNEL) && in_eeprom(dst_start);
	assign ee_rd = (CHANNEL == EEPROM_CHANNEL) && in_eeprom(src_start);

	always_comb begin
		if ((ee_wr || ee_rd) && item.eeprom_present) begin
			kind_start = ee_wr ? KIND_EEPROM_WR : KIND_EEPROM_RD;
		end else begin
			kind_start = cfg.word_mode ? KIND_WORD : KIND_HALF;
		end
	end

	always_comb begin
		result.read_address  = src_addr_q;
		result.write_address = dst_addr_q;
		result.access_kind   = kind_q;
		result.last_unit     = last;
		result.enable_after  = last & cfg.repeat_mode;
		result.irq_pulse     = last & cfg.irq_enable;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= 1'b0;
			units_left_q <= '0;
			src_addr_q   <= '0;
			dst_addr_q   <= '0;
			src_step_q   <= '0;
			dst_step_q   <= '0;
			kind_q       <= KIND_HALF;
		end else if (fire) begin
			if (is_start) begin
				running_q    <= 1'b1;
				units_left_q <= cfg.unit_count;
				src_addr_q   <= src_start;
				dst_addr_q   <= dst_start;
				src_step_q   <= step_for(cfg.source_control, cfg.word_mode);
				dst_step_q   <= step_for(cfg.dest_control, cfg.word_mode);
				kind_q       <= kind_start;
			end else if (zero_run) begin
				running_q <= 1'b0;
			end else if (produce) begin
				src_addr_q   <= src_addr_q + widen(src_step_q);
				dst_addr_q   <= dst_addr_q + widen(dst_step_q);
				units_left_q <= units_left_q - COUNT_W'(1);
				if (last) begin
					running_q <= 1'b0;
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_last_stops: assert property (@(posedge clk) disable iff (!arst_n)
		fire && produce && last |=> !running_q)
		else $error("run did not stop after last unit");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		fire && produce |=> units_left_q == $past(units_left_q) - COUNT_W'(1))
		else $error("unit count did not decrement on a step");

	a_start_loads: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_start |=> running_q && units_left_q == $past(cfg.unit_count))
		else $error("start did not arm the channel");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.op == OP_STEP && !running_q |=> $stable(src_addr_q) && $stable(dst_addr_q))
		else $error("addresses moved on a step while idle");
`endif

endmodule

// ----- test/tb_dma_channel_address_sequencer.sv -----
module tb_dma_channel_address_sequencer;
	import dcas_pkg::*;

	// handshake pacing and run limits
	localparam int unsigned QUIET_CYCLES = 4;    // pipeline depth plus margin, before cfg writes
	localparam int unsigned HOLD_CYCLES  = 200;  // long output hold-off in the stall test
	localparam int unsigned STALL_LIMIT  = 3000; // cycles with no word moving on either side
	localparam int unsigned RANDOM_WORDS = 1040;

	// cartridge EEPROM window, upper bound exclusive
	localparam logic [ADDR_W-1:0] EEPROM_LO = 32'h0D00_0000;
	localparam logic [ADDR_W-1:0] EEPROM_HI = 32'h0E00_0000;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data  = '0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata   = '0;  // [0] reload_request, [1] eeprom_present, [7:2] zero
	logic             s_tuser   = 1'b0; // [0] op
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [71:0]      m_tdata;          // [31:0] read_address, [63:32] write_address,
	                                    // [64] enable_after, [65] irq_pulse, [71:66] zero
	logic [1:0]       m_tuser;          // [1:0] access_kind
	logic             m_tlast;          // last_unit

	dma_channel_address_sequencer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// shadow of the register file, as last written
	cfg_t regs;

	// predicted channel state
	logic               ch_armed;
	logic [COUNT_W-1:0] ch_left;
	logic [ADDR_W-1:0]  ch_src;
	logic [ADDR_W-1:0]  ch_dst;
	logic [STEP_W-1:0]  ch_src_delta;
	logic [STEP_W-1:0]  ch_dst_delta;
	kind_t              ch_kind;

	// transfers predicted but not yet seen on the master side, oldest first
	result_t expected_transfers[$];

	// pacing controls for the sender task and the receiver process
	bit          tx_steady   = 1'b0; // sender offers every cycle
	bit          rx_steady   = 1'b0; // receiver always ready
	int unsigned rx_hold_req = 0;    // nonzero: receiver holds off this many cycles
	int unsigned rx_stall    = 0;

	int unsigned words_sent;
	int unsigned live_words;       // starts, and steps on an armed channel
	int unsigned transfers_checked;
	int unsigned runs_done;
	int unsigned cfg_writes;
	int unsigned mismatches;
	int unsigned quiet_cycles;

	// mostly short gaps, now and then a long one
	function automatic int unsigned idle_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [ADDR_W-1:0] pick_address();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return EEPROM_LO + $urandom_range(0, 15);
			3: return EEPROM_HI - $urandom_range(1, 16);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic in_eeprom_window(logic [ADDR_W-1:0] a);
		return (a >= EEPROM_LO) && (a < EEPROM_HI);
	endfunction

	// signed byte delta per unit: 2 or 4 bytes, negated for decrement, zero for fixed
	function automatic logic [STEP_W-1:0] unit_delta(ctrl_t ctrl, logic word);
		logic [STEP_W-1:0] bytes;
		bytes = word ? 4'd4 : 4'd2;
		if (ctrl == CTRL_FIXED)
			return '0;
		if (ctrl == CTRL_DEC)
			return ~bytes + 4'd1;
		return bytes;
	endfunction

	// Advance the predicted channel by one accepted word; returns 1 when a transfer
	// comes out of it, with the transfer in r.
	function automatic bit model_word(item_t w, output result_t r);
		logic [ADDR_W-1:0] keep;
		logic              hit_wr;
		logic              hit_rd;
		r = '0;
		if (w.op == OP_START) begin
			keep = regs.word_mode ? 32'hFFFF_FFFC : 32'hFFFF_FFFE;
			ch_armed = 1'b1;
			ch_left  = regs.unit_count;
			if (w.reload_request) begin
				ch_src = regs.source_base;
				ch_dst = regs.dest_base;
			end else if (regs.repeat_mode && regs.dest_control == CTRL_INC_RELOAD) begin
				ch_dst = regs.dest_base;
			end
			ch_src &= keep;
			ch_dst &= keep;
			ch_src_delta = unit_delta(regs.source_control, regs.word_mode);
			ch_dst_delta = unit_delta(regs.dest_control, regs.word_mode);
			// EEPROM kinds only exist on the EEPROM channel; write wins over read
			hit_wr = (CHANNEL == EEPROM_CHANNEL) && in_eeprom_window(ch_dst);
			hit_rd = (CHANNEL == EEPROM_CHANNEL) && in_eeprom_window(ch_src);
			if ((hit_wr || hit_rd) && w.eeprom_present)
				ch_kind = hit_wr ? KIND_EEPROM_WR : KIND_EEPROM_RD;
			else
				ch_kind = regs.word_mode ? KIND_WORD : KIND_HALF;
			return 1'b0;
		end
		if (!ch_armed)
			return 1'b0;
		// armed with a zero count: the run just ends, nothing is emitted
		if (ch_left == 0) begin
			ch_armed = 1'b0;
			return 1'b0;
		end
		r.read_address  = ch_src;
		r.write_address = ch_dst;
		r.access_kind   = ch_kind;
		ch_src += {{(ADDR_W-STEP_W){ch_src_delta[STEP_W-1]}}, ch_src_delta};
		ch_dst += {{(ADDR_W-STEP_W){ch_dst_delta[STEP_W-1]}}, ch_dst_delta};
		ch_left--;
		if (ch_left == 0) begin
			// repeat and irq enable are taken as they stand now, not as at start
			ch_armed       = 1'b0;
			r.last_unit    = 1'b1;
			r.enable_after = regs.repeat_mode;
			r.irq_pulse    = regs.irq_enable;
		end
		return 1'b1;
	endfunction

	// Register write; only called with the pipeline empty. cfg_we is lowered by
	// whatever comes next, so back-to-back writes keep it high.
	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_writes++;
		case (idx)
			REG_SOURCE_BASE:    regs.source_base    = val;
			REG_DEST_BASE:      regs.dest_base      = val;
			REG_WORD_MODE:      regs.word_mode      = val[0];
			REG_SOURCE_CONTROL: regs.source_control = ctrl_t'(val[1:0]);
			REG_DEST_CONTROL:   regs.dest_control   = ctrl_t'(val[1:0]);
			REG_REPEAT_MODE:    regs.repeat_mode    = val[0];
			REG_IRQ_ENABLE:     regs.irq_enable     = val[0];
			REG_UNIT_COUNT:     regs.unit_count     = val[COUNT_W-1:0];
			default: ;
		endcase
	endtask

	// Offer one word on the slave side and wait for the handshake. tvalid stays high
	// afterwards unless the next call opens a gap or the pipeline is drained.
	task automatic send_word(op_t op, logic reload, logic eeprom);
		item_t       w;
		result_t     r;
		int unsigned gap;
		w.op             = op;
		w.reload_request = reload;
		w.eeprom_present = eeprom;
		gap = (!tx_steady && $urandom_range(0, 99) < 25) ? idle_len() : 0;
		cfg_we <= 1'b0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {6'b0, eeprom, reload};
		do @(posedge clk); while (!s_tready);
		words_sent++;
		if (op == OP_START || ch_armed)
			live_words++;
		if (model_word(w, r))
			expected_transfers.push_back(r);
	endtask

	// Stop offering, wait for every predicted transfer, then let a step that
	// produces nothing clear the pipeline too.
	task automatic drain_channel();
		s_tvalid <= 1'b0;
		cfg_we   <= 1'b0;
		while (expected_transfers.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// steps on an idle channel, then one unit with every register at reset value
	task automatic test_idle_and_defaults();
		send_word(OP_STEP, 1'b1, 1'b1);
		send_word(OP_START, 1'b0, 1'b0);
		send_word(OP_STEP, 1'b0, 1'b0);
		send_word(OP_STEP, 1'b0, 1'b1);
		drain_channel();
	endtask

	// all-ones bases, word alignment, source decrementing from the top,
	// destination incrementing across the top; step fields set to be ignored
	task automatic test_address_extremes();
		write_reg(REG_SOURCE_BASE, 32'hFFFF_FFFF);
		write_reg(REG_DEST_BASE, 32'hFFFF_FFFF);
		write_reg(REG_WORD_MODE, 32'd1);
		write_reg(REG_SOURCE_CONTROL, CFG_W'(CTRL_DEC));
		write_reg(REG_DEST_CONTROL, CFG_W'(CTRL_INC));
		write_reg(REG_REPEAT_MODE, 32'd1);
		write_reg(REG_IRQ_ENABLE, 32'd1);
		write_reg(REG_UNIT_COUNT, 32'd3);
		send_word(OP_START, 1'b1, 1'b1);
		repeat (3) send_word(OP_STEP, 1'b1, 1'b1);
		drain_channel();
	endtask

	// repeat with reload control: only the destination reloads, halfword aligned;
	// source stays where the last run left it and does not move
	task automatic test_dest_reload();
		write_reg(REG_WORD_MODE, 32'd0);
		write_reg(REG_SOURCE_CONTROL, CFG_W'(CTRL_FIXED));
		write_reg(REG_DEST_CONTROL, CFG_W'(CTRL_INC_RELOAD));
		write_reg(REG_DEST_BASE, EEPROM_LO | 32'd1);
		write_reg(REG_IRQ_ENABLE, 32'd0);
		write_reg(REG_UNIT_COUNT, 32'd2);
		send_word(OP_START, 1'b0, 1'b1);
		repeat (2) send_word(OP_STEP, 1'b0, 1'b0);
		drain_channel();
	endtask

	// zero count, count field all ones, full 64K count, restarts mid-run
	task automatic test_count_corners();
		write_reg(REG_UNIT_COUNT, 32'd0);
		send_word(OP_START, 1'b1, 1'b0);
		send_word(OP_STEP, 1'b0, 1'b0);
		send_word(OP_STEP, 1'b1, 1'b1);
		drain_channel();
		write_reg(REG_UNIT_COUNT, 32'hFFFF_FFFF);
		send_word(OP_START, 1'b1, 1'b0);
		repeat (3) send_word(OP_STEP, 1'b0, 1'b1);
		drain_channel();
		write_reg(REG_UNIT_COUNT, 32'd65536);
		send_word(OP_START, 1'b0, 1'b0);
		repeat (2) send_word(OP_STEP, 1'b1, 1'b0);
		drain_channel();
	endtask

	// full rate on both sides for one long run
	task automatic test_back_to_back();
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		write_reg(REG_WORD_MODE, 32'd1);
		write_reg(REG_SOURCE_CONTROL, CFG_W'(CTRL_INC));
		write_reg(REG_DEST_CONTROL, CFG_W'(CTRL_DEC));
		write_reg(REG_UNIT_COUNT, 32'd48);
		send_word(OP_START, 1'b1, 1'b0);
		repeat (48) send_word(OP_STEP, 1'b0, 1'b0);
		drain_channel();
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// receiver holds off for a long stretch while the sender keeps offering,
	// so the block fills and drops s_tready; then the sender waits for the tail
	task automatic test_output_stall();
		tx_steady = 1'b1;
		write_reg(REG_UNIT_COUNT, 32'd24);
		rx_hold_req <= HOLD_CYCLES;
		send_word(OP_START, 1'b1, 1'b1);
		repeat (24) send_word(OP_STEP, 1'b0, 1'b0);
		tx_steady = 1'b0;
		drain_channel();
	endtask

	// Random phases: reshuffle part of the register file, then a few well-formed
	// runs with random content, sometimes cut short by a restart or followed by
	// steps on an idle channel; an occasional burst of arbitrary words.
	task automatic test_random_runs(int unsigned target);
		int unsigned       goal;
		int unsigned       steps;
		int unsigned       r;
		logic [CFG_W-1:0]  cnt;
		goal = live_words + target;
		while (live_words < goal) begin
			drain_channel();
			if ($urandom_range(0, 1)) write_reg(REG_SOURCE_BASE, pick_address());
			if ($urandom_range(0, 1)) write_reg(REG_DEST_BASE, pick_address());
			// narrow registers get random upper data bits
			if ($urandom_range(0, 1)) write_reg(REG_WORD_MODE, $urandom());
			if ($urandom_range(0, 1)) write_reg(REG_SOURCE_CONTROL, $urandom());
			if ($urandom_range(0, 1)) write_reg(REG_DEST_CONTROL, $urandom());
			if ($urandom_range(0, 1)) write_reg(REG_REPEAT_MODE, $urandom());
			if ($urandom_range(0, 1)) write_reg(REG_IRQ_ENABLE, $urandom());
			if ($urandom_range(0, 1)) begin
				r = $urandom_range(0, 99);
				if (r < 6)
					cnt = 0;
				else if (r < 9)
					cnt = 32'd65536;
				else if (r < 11)
					cnt = $urandom();
				else if (r < 30)
					cnt = $urandom_range(7, 24);
				else
					cnt = $urandom_range(1, 6);
				write_reg(REG_UNIT_COUNT, cnt);
			end
			if ($urandom_range(0, 99) < 10)
				repeat ($urandom_range(3, 8))
					send_word(op_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
			repeat ($urandom_range(1, 3)) begin
				send_word(OP_START, $urandom_range(0, 9) < 7, 1'($urandom_range(0, 1)));
				// huge counts are only sampled, the next start cuts them off
				if (regs.unit_count > 40)
					steps = $urandom_range(1, 12);
				else if ($urandom_range(0, 99) < 15)
					steps = $urandom_range(0, regs.unit_count);
				else
					steps = regs.unit_count +
						(($urandom_range(0, 99) < 20) ? $urandom_range(1, 2) : 0);
				repeat (steps)
					send_word(OP_STEP, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
			// now and then a phase with no idling on one side
			tx_steady = ($urandom_range(0, 9) == 0);
			rx_steady = ($urandom_range(0, 9) == 0);
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// master side pacing; a hold request overrides the random gaps
	always @(posedge clk) begin
		if (rx_hold_req != 0) begin
			rx_stall = rx_hold_req;
			rx_hold_req <= 0;
		end else if (rx_stall == 0 && !rx_steady && $urandom_range(0, 99) < 20) begin
			rx_stall = idle_len();
		end
		if (rx_stall != 0) begin
			rx_stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// compare every word taken on the master side with the oldest prediction
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.read_address  = m_tdata[31:0];
			got.write_address = m_tdata[63:32];
			got.enable_after  = m_tdata[64];
			got.irq_pulse     = m_tdata[65];
			got.access_kind   = kind_t'(m_tuser);
			got.last_unit     = m_tlast;
			if (expected_transfers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: transfer with none pending: rd %h wr %h kind %0d last %b",
						got.read_address, got.write_address, got.access_kind, got.last_unit);
			end else begin
				want = expected_transfers.pop_front();
				transfers_checked++;
				if (got.last_unit)
					runs_done++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("ERROR: transfer %0d mismatch", transfers_checked);
						$display("  expected rd %h wr %h kind %0d last %b en %b irq %b",
							want.read_address, want.write_address, want.access_kind,
							want.last_unit, want.enable_after, want.irq_pulse);
						$display("  actual   rd %h wr %h kind %0d last %b en %b irq %b",
							got.read_address, got.write_address, got.access_kind,
							got.last_unit, got.enable_after, got.irq_pulse);
					end
				end
			end
		end
	end

	// hang detection: no word moving on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("ERROR: no handshake for %0d cycles, %0d transfers pending",
				quiet_cycles, expected_transfers.size());
			$display("** dma_channel_address_sequencer: FAILED **");
			$finish;
		end
	end

	initial begin
		regs            = '0;
		regs.unit_count = COUNT_W'(1);
		ch_armed        = 1'b0;
		ch_left         = '0;
		ch_src          = '0;
		ch_dst          = '0;
		ch_src_delta    = '0;
		ch_dst_delta    = '0;
		ch_kind         = KIND_HALF;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_and_defaults();
		test_address_extremes();
		test_dest_reload();
		test_count_corners();
		test_back_to_back();
		test_output_stall();
		test_random_runs(RANDOM_WORDS);
		drain_channel();

		$display("Run: %0d words sent (%0d starts or armed steps), %0d register writes",
			words_sent, live_words, cfg_writes);
		$display("Run: %0d transfers checked over %0d completed runs, %0d mismatches",
			transfers_checked, runs_done, mismatches);
		if (mismatches == 0)
			$display("** dma_channel_address_sequencer: PASSED **");
		else
			$display("** dma_channel_address_sequencer: FAILED **");
		$finish;
	end

endmodule
